@@ rtl/core/qau_pkg.sv @@
// Shared types, constants and fixed-point helpers of the quaternion arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package qau_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;

   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int SUM_BITS  = 2 * WORD_BITS + 2;
   localparam int SQ_BITS   = 2 * WORD_BITS + 1;
   localparam int ROOT_BITS = WORD_BITS + 1;
   localparam int QUO_BITS  = FRAC_BITS + 2;
   localparam int REM_BITS  = WORD_BITS + FRAC_BITS + 3;

   // Square root stages, divider stages and the final sign and saturation stage.
   localparam int NORM_LAT = ROOT_BITS + QUO_BITS + 1;
   // Clock edges from the accepting edge to the edge that samples rsp_valid.
   localparam int RSP_LAT  = NORM_LAT + 4;

   localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(2 ** (FRAC_BITS - 1));

   typedef enum logic [2:0] {
      OP_QMUL  = 3'd0,
      OP_VMUL  = 3'd1,
      OP_SCALE = 3'd2,
      OP_ADD   = 3'd3,
      OP_NEG   = 3'd4,
      OP_NORM  = 3'd5
   } op_type;

   // Operand indexes (w, x, y, z) of the sixteen products of the Hamilton product.
   localparam logic [1:0] PROD_A [16] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
                                          2'd0, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2};
   localparam logic [1:0] PROD_B [16] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2,
                                          2'd2, 2'd0, 2'd1, 2'd3, 2'd3, 2'd0, 2'd2, 2'd1};

   typedef struct packed {
      logic [2:0]                  op;
      logic signed [WORD_BITS-1:0] a_w;
      logic signed [WORD_BITS-1:0] a_x;
      logic signed [WORD_BITS-1:0] a_y;
      logic signed [WORD_BITS-1:0] a_z;
      logic signed [WORD_BITS-1:0] b_w;
      logic signed [WORD_BITS-1:0] b_x;
      logic signed [WORD_BITS-1:0] b_y;
      logic signed [WORD_BITS-1:0] b_z;
      logic signed [WORD_BITS-1:0] factor;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] r_w;
      logic signed [WORD_BITS-1:0] r_x;
      logic signed [WORD_BITS-1:0] r_y;
      logic signed [WORD_BITS-1:0] r_z;
      logic                        overflow;
      logic                        zero_length;
   } rsp_type;

   // Returns {overflow, word}: the value clamped to the signed word range.
   function automatic logic [WORD_BITS:0] sat_word(input logic signed [SUM_BITS-1:0] v);
      logic [WORD_BITS-1:0] lo;
      lo = v[WORD_BITS-1:0];
      if (v == {{(SUM_BITS-WORD_BITS){lo[WORD_BITS-1]}}, lo}) begin
         return {1'b0, lo};
      end else if (v[SUM_BITS-1]) begin
         return {1'b1, WORD_MIN};
      end else begin
         return {1'b1, WORD_MAX};
      end
   endfunction

   // Round to nearest with ties upward, drop the fraction bits, then saturate.
   function automatic logic [WORD_BITS:0] round_sat(input logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] r;
      r = v + ROUND_HALF;
      return sat_word(r >>> FRAC_BITS);
   endfunction

   function automatic rsp_type pack_rsp(input logic [3:0][WORD_BITS-1:0] w,
                                        input logic ovf, input logic zl);
      rsp_type r;
      r.r_w         = w[0];
      r.r_x         = w[1];
      r.r_y         = w[2];
      r.r_z         = w[3];
      r.overflow    = ovf;
      r.zero_length = zl;
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/qau_norm.sv @@
// Normalization pipeline: bit-serial square root stages followed by divider stages and a sign stage.
`timescale 1ns / 1ps
`default_nettype none
module qau_norm import qau_pkg::*; (
   input  logic                      clock,
   input  logic [SQ_BITS-1:0]        sum_sq,
   input  logic [3:0][WORD_BITS-1:0] mag,
   input  logic [3:0]                neg,
   output rsp_type                   norm_rsp
);

   typedef struct packed {
      logic [3:0][WORD_BITS-1:0] mag;
      logic [3:0]                neg;
      logic                      zero;
   } side_type;

   logic [2*ROOT_BITS-1:0] sq_rad_ff  [ROOT_BITS];
   logic [2*ROOT_BITS-1:0] sq_rad_in  [ROOT_BITS];
   logic [ROOT_BITS+1:0]   sq_rem_ff  [ROOT_BITS];
   logic [ROOT_BITS+1:0]   sq_rem_in  [ROOT_BITS];
   logic [ROOT_BITS-1:0]   sq_root_ff [ROOT_BITS];
   logic [ROOT_BITS-1:0]   sq_root_in [ROOT_BITS];
   side_type               sq_side_ff [ROOT_BITS];
   side_type               sq_side_in [ROOT_BITS];

   logic [REM_BITS-1:0]    dv_rem_ff  [QUO_BITS][4];
   logic [REM_BITS-1:0]    dv_rem_in  [QUO_BITS][4];
   logic [QUO_BITS-1:0]    dv_quo_ff  [QUO_BITS][4];
   logic [QUO_BITS-1:0]    dv_quo_in  [QUO_BITS][4];
   logic [ROOT_BITS:0]     dv_div_ff  [QUO_BITS];
   logic [ROOT_BITS:0]     dv_div_in  [QUO_BITS];
   side_type               dv_side_ff [QUO_BITS];
   side_type               dv_side_in [QUO_BITS];

   rsp_type                norm_rsp_ff;
   rsp_type                norm_rsp_in;

   // Each square root stage takes two radicand bits and decides one root bit.
   always_comb begin
      logic [2*ROOT_BITS-1:0] rad_src;
      logic [ROOT_BITS+1:0]   rem_src;
      logic [ROOT_BITS-1:0]   root_src;
      logic [ROOT_BITS+1:0]   cur;
      logic [ROOT_BITS+1:0]   trial;
      side_type               side_src;
      for (int k = 0; k < ROOT_BITS; k++) begin
         if (k == 0) begin
            rad_src  = (2*ROOT_BITS)'(sum_sq);
            rem_src  = '0;
            root_src = '0;
            side_src = '{mag: mag, neg: neg, zero: (sum_sq == '0)};
         end else begin
            rad_src  = sq_rad_ff[k-1];
            rem_src  = sq_rem_ff[k-1];
            root_src = sq_root_ff[k-1];
            side_src = sq_side_ff[k-1];
         end
         cur   = {rem_src[ROOT_BITS-1:0], rad_src[2*ROOT_BITS-1 -: 2]};
         trial = {root_src, 2'b01};
         if (cur >= trial) begin
            sq_rem_in[k]  = cur - trial;
            sq_root_in[k] = {root_src[ROOT_BITS-2:0], 1'b1};
         end else begin
            sq_rem_in[k]  = cur;
            sq_root_in[k] = {root_src[ROOT_BITS-2:0], 1'b0};
         end
         sq_rad_in[k]  = rad_src << 2;
         sq_side_in[k] = side_src;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ROOT_BITS; k++) begin
         sq_rad_ff[k]  <= sq_rad_in[k];
         sq_rem_ff[k]  <= sq_rem_in[k];
         sq_root_ff[k] <= sq_root_in[k];
         sq_side_ff[k] <= sq_side_in[k];
      end
   end

   // Each component computes (2*m*2^F + len) / (2*len), which rounds half away from zero.
   // The quotient never exceeds 2^F + 1 because len is at least m, so QUO_BITS steps suffice.
   always_comb begin
      logic [ROOT_BITS:0]   div_src;
      logic [REM_BITS-1:0]  rem_src [4];
      logic [QUO_BITS-1:0]  quo_src [4];
      logic [REM_BITS-1:0]  shifted;
      side_type             side_src;
      for (int j = 0; j < QUO_BITS; j++) begin
         if (j == 0) begin
            div_src  = {sq_root_ff[ROOT_BITS-1], 1'b0};
            side_src = sq_side_ff[ROOT_BITS-1];
            for (int c = 0; c < 4; c++) begin
               rem_src[c] = (REM_BITS'(side_src.mag[c]) << (FRAC_BITS + 1))
                          + REM_BITS'(sq_root_ff[ROOT_BITS-1]);
               quo_src[c] = '0;
            end
         end else begin
            div_src  = dv_div_ff[j-1];
            side_src = dv_side_ff[j-1];
            for (int c = 0; c < 4; c++) begin
               rem_src[c] = dv_rem_ff[j-1][c];
               quo_src[c] = dv_quo_ff[j-1][c];
            end
         end
         shifted = REM_BITS'(div_src) << (QUO_BITS - 1 - j);
         for (int c = 0; c < 4; c++) begin
            if (rem_src[c] >= shifted) begin
               dv_rem_in[j][c] = rem_src[c] - shifted;
               dv_quo_in[j][c] = {quo_src[c][QUO_BITS-2:0], 1'b1};
            end else begin
               dv_rem_in[j][c] = rem_src[c];
               dv_quo_in[j][c] = {quo_src[c][QUO_BITS-2:0], 1'b0};
            end
         end
         dv_div_in[j]  = div_src;
         dv_side_in[j] = side_src;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < QUO_BITS; j++) begin
         for (int c = 0; c < 4; c++) begin
            dv_rem_ff[j][c] <= dv_rem_in[j][c];
            dv_quo_ff[j][c] <= dv_quo_in[j][c];
         end
         dv_div_ff[j]  <= dv_div_in[j];
         dv_side_ff[j] <= dv_side_in[j];
      end
   end

   // Apply the sign, saturate, and force zero for a zero-length input.
   always_comb begin
      logic signed [SUM_BITS-1:0] v;
      logic [WORD_BITS:0]         sw;
      logic [3:0][WORD_BITS-1:0]  w;
      logic                       ovf;
      side_type                   side;
      side = dv_side_ff[QUO_BITS-1];
      ovf  = 1'b0;
      for (int c = 0; c < 4; c++) begin
         v = $signed(SUM_BITS'(dv_quo_ff[QUO_BITS-1][c]));
         if (side.neg[c]) begin
            v = -v;
         end
         sw   = sat_word(v);
         w[c] = sw[WORD_BITS-1:0];
         ovf  = ovf | sw[WORD_BITS];
      end
      if (side.zero) begin
         norm_rsp_in = pack_rsp('0, 1'b0, 1'b1);
      end else begin
         norm_rsp_in = pack_rsp(w, ovf, 1'b0);
      end
   end

   always_ff @(posedge clock) begin
      norm_rsp_ff <= norm_rsp_in;
   end

   assign norm_rsp = norm_rsp_ff;

endmodule
`default_nettype wire

@@ rtl/core/quaternion_arithmetic_unit.sv @@
// Top level of the quaternion arithmetic unit: operand select, products, sums and output.
// A result reaches the rsp_ ports through three front stages, 33 square root stages,
// 18 divider stages, the sign stage and the output register. Throughput: one item per
// cycle while busy is low; every operation runs through the same fixed-length pipeline,
// so results leave in order. busy is a registered copy of reset: it is high during reset
// and in the cycle after it. Reset is synchronous; it clears the valid bits and sets busy.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_arithmetic_unit import qau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic busy_ff;

   logic                        v1_ff;
   logic [2:0]                  op1_ff;
   logic signed [WORD_BITS-1:0] a1_ff [4];
   logic signed [WORD_BITS-1:0] b1_ff [4];
   logic signed [WORD_BITS-1:0] b1_in [4];

   logic                        v2_ff;
   logic [2:0]                  op2_ff;
   logic signed [PROD_BITS-1:0] prod2_ff [16];
   logic signed [WORD_BITS-1:0] a2_ff [4];
   logic signed [WORD_BITS-1:0] b2_ff [4];
   logic [3:0][WORD_BITS-1:0]   mag2_ff;
   logic [3:0]                  neg2_ff;

   logic                        v3_ff;
   logic [2:0]                  op3_ff;
   logic                        rnd3_ff;
   logic signed [SUM_BITS-1:0]  s3_ff [4];
   logic signed [SUM_BITS-1:0]  s3_in [4];
   logic [3:0][WORD_BITS-1:0]   mag3_ff;
   logic [3:0]                  neg3_ff;

   logic                        v4_ff;
   logic                        norm4_ff;
   rsp_type                     res4_ff;
   rsp_type                     res4_in;

   logic                        dl_v_ff    [NORM_LAT-1];
   logic                        dl_norm_ff [NORM_LAT-1];
   rsp_type                     dl_res_ff  [NORM_LAT-1];

   rsp_type                     norm_rsp;
   logic                        rsp_valid_ff;
   rsp_type                     rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   // Route the second operand so that products 0..3 also serve scale and squares; a vector product zeroes b_w.
   always_comb begin
      b1_in[0] = req_data.b_w;
      b1_in[1] = req_data.b_x;
      b1_in[2] = req_data.b_y;
      b1_in[3] = req_data.b_z;
      case (req_data.op)
         OP_VMUL: begin
            b1_in[0] = '0;
         end
         OP_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               b1_in[i] = req_data.factor;
            end
         end
         OP_NORM: begin
            b1_in[0] = req_data.a_w;
            b1_in[1] = req_data.a_x;
            b1_in[2] = req_data.a_y;
            b1_in[3] = req_data.a_z;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff   <= req_data.op;
      a1_ff[0] <= req_data.a_w;
      a1_ff[1] <= req_data.a_x;
      a1_ff[2] <= req_data.a_y;
      a1_ff[3] <= req_data.a_z;
      for (int i = 0; i < 4; i++) begin
         b1_ff[i] <= b1_in[i];
      end
   end

   always_ff @(posedge clock) begin
      op2_ff <= op1_ff;
      for (int k = 0; k < 16; k++) begin
         prod2_ff[k] <= a1_ff[PROD_A[k]] * b1_ff[PROD_B[k]];
      end
      for (int i = 0; i < 4; i++) begin
         a2_ff[i]   <= a1_ff[i];
         b2_ff[i]   <= b1_ff[i];
         neg2_ff[i] <= a1_ff[i][WORD_BITS-1];
         mag2_ff[i] <= a1_ff[i][WORD_BITS-1] ? WORD_BITS'(-a1_ff[i]) : a1_ff[i];
      end
   end

   always_comb begin
      logic signed [SUM_BITS-1:0] p [16];
      for (int k = 0; k < 16; k++) begin
         p[k] = SUM_BITS'(prod2_ff[k]);
      end
      for (int i = 0; i < 4; i++) begin
         s3_in[i] = '0;
      end
      case (op2_ff)
         OP_QMUL, OP_VMUL: begin
            s3_in[0] = p[0] - p[1] - p[2] - p[3];
            s3_in[1] = p[4] + p[5] + p[6] - p[7];
            s3_in[2] = p[8] + p[9] + p[10] - p[11];
            s3_in[3] = p[12] + p[13] + p[14] - p[15];
         end
         OP_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               s3_in[i] = p[i];
            end
         end
         OP_ADD: begin
            for (int i = 0; i < 4; i++) begin
               s3_in[i] = SUM_BITS'(a2_ff[i]) + SUM_BITS'(b2_ff[i]);
            end
         end
         OP_NEG: begin
            for (int i = 0; i < 4; i++) begin
               s3_in[i] = -SUM_BITS'(a2_ff[i]);
            end
         end
         OP_NORM: begin
            s3_in[0] = p[0] + p[1] + p[2] + p[3];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op3_ff  <= op2_ff;
      rnd3_ff <= (op2_ff == OP_QMUL) || (op2_ff == OP_VMUL) || (op2_ff == OP_SCALE);
      for (int i = 0; i < 4; i++) begin
         s3_ff[i] <= s3_in[i];
      end
      mag3_ff <= mag2_ff;
      neg3_ff <= neg2_ff;
   end

   always_comb begin
      logic [WORD_BITS:0]        sw;
      logic [3:0][WORD_BITS-1:0] w;
      logic                      ovf;
      ovf = 1'b0;
      for (int i = 0; i < 4; i++) begin
         sw   = rnd3_ff ? round_sat(s3_ff[i]) : sat_word(s3_ff[i]);
         w[i] = sw[WORD_BITS-1:0];
         ovf  = ovf | sw[WORD_BITS];
      end
      res4_in = pack_rsp(w, ovf, 1'b0);
   end

   always_ff @(posedge clock) begin
      norm4_ff <= (op3_ff == OP_NORM);
      res4_ff  <= res4_in;
   end

   qau_norm u_norm (
      .clock    (clock),
      .sum_sq   (s3_ff[0][SQ_BITS-1:0]),
      .mag      (mag3_ff),
      .neg      (neg3_ff),
      .norm_rsp (norm_rsp)
   );

   // The other operations wait in this delay line so that every result leaves in order.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NORM_LAT - 1; i++) begin
            dl_v_ff[i] <= 1'b0;
         end
      end else begin
         dl_v_ff[0] <= v4_ff;
         for (int i = 1; i < NORM_LAT - 1; i++) begin
            dl_v_ff[i] <= dl_v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      dl_norm_ff[0] <= norm4_ff;
      dl_res_ff[0]  <= res4_ff;
      for (int i = 1; i < NORM_LAT - 1; i++) begin
         dl_norm_ff[i] <= dl_norm_ff[i-1];
         dl_res_ff[i]  <= dl_res_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dl_v_ff[NORM_LAT-2];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= dl_norm_ff[NORM_LAT-2] ? norm_rsp : dl_res_ff[NORM_LAT-2];
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/qau_checker.sv @@
// Port-level checks of the quaternion arithmetic unit and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module qau_checker import qau_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // The unit holds off transfers only while it comes out of reset.
   a_busy_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) || busy == 1'b0)
      else $error("busy high outside reset recovery");

   // Every result comes from a transfer a fixed number of cycles earlier.
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, RSP_LAT))
      else $error("result without a matching input transfer");

   // Only a normalize request can report a zero-length input.
   a_zero_from_norm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_length |-> $past(req_data.op, RSP_LAT) == OP_NORM)
      else $error("zero_length on a request other than normalize");

   // A zero-length result is all zero and never saturated.
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_length |->
         !rsp_data.overflow && rsp_data.r_w == '0 && rsp_data.r_x == '0 &&
         rsp_data.r_y == '0 && rsp_data.r_z == '0)
      else $error("zero-length result carries data");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (.*);
`default_nettype wire
